// ===== rtl/npds_pkg.sv =====
`default_nettype none

package npds_pkg;

    // Fixed widths of the result fields
    localparam int DIST_W = 13;
    localparam int NIDX_W = 10;

    // Per-axis difference is clamped to 16 bits before squaring
    localparam int DIFF_W = 16;
    localparam int SQR_W  = 2 * DIFF_W;
    localparam int SUM_W  = SQR_W + 2;

    // Squared distance held for the winner; cutoff is 999.0 in Q.16
    localparam int BEST_W = 26;
    localparam logic [BEST_W-1:0] CUTOFF_SQ = BEST_W'(999 * 65536);
    localparam logic [DIFF_W-1:0] DIFF_CLAMP = '1;

    // Digit-by-digit square root over BEST_W bits, one result bit per cycle
    localparam int ROOT_W = BEST_W + 1;
    localparam logic [ROOT_W-1:0] ROOT_BIT_INIT = ROOT_W'(1) << (BEST_W - 2);

    // Input kinds carried in tuser
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SQRT,
        ST_RESULT
    } state_t;

endpackage : npds_pkg

`default_nettype wire

// ===== rtl/nearest_point_distance_search.sv =====
// Nearest stored point search over a list of 3D points.
// Input stream (s_*): tdata carries coord_x, coord_y, coord_z (signed Q15.8,
// COORD_BITS each, x lowest), tuser[0] is mode (0 load, 1 query), tuser[1]
// is restart, tlast is the batch-final flag of a query.
// Output stream (m_*): one transaction per query; tdata carries distance
// (bits 12:0) and nearest_index (bits 22:13), tuser is found, tlast echoes
// the query's final flag.
// A load writes the point into the point memory at the edge it is
// accepted. Loads past MAX_POINTS are dropped unless restart is set. A
// query reads one stored point per cycle through a four-stage
// read/difference/square/compare pipe, then runs a bit-serial square root.
// The single read port of the point memory sets that scan rate.
// s_tready is high only while no query is in progress; the finished result
// sits in an output register, so the next transaction is taken while the
// result still waits for m_tready. A second result waits until that
// register is free. Reset empties the list and drops any pending result;
// the memory itself is not cleared.
`default_nettype none

module nearest_point_distance_search
    import npds_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // coord_x, coord_y, coord_z, zero fill
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // mode, restart
    input  wire logic [1:0]                        s_tuser,
    input  wire logic                              s_tlast,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // distance, nearest_index, zero fill
    output logic [23:0]                            m_tdata,
    // found
    output logic [0:0]                             m_tuser,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready
);

    localparam int PT_W    = 3 * COORD_BITS;
    localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SDIF_W  = COORD_BITS + 1;

    // Point memory: {z, y, x}
    logic [PT_W-1:0] point_mem [MAX_POINTS];

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_ptr_reg;

    logic [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;
    logic                  final_reg;

    // Pipe registers
    logic [PT_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]  idx1_reg, idx2_reg, idx3_reg;
    logic              v1_reg, v2_reg, v3_reg;
    logic [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [SQR_W-1:0]  sx_reg, sy_reg, sz_reg;

    // Running winner
    logic [BEST_W-1:0] best_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic              hit_reg;

    // Square root
    logic [ROOT_W-1:0] sq_rem_reg, sq_root_reg, sq_bit_reg;

    // Output register
    logic              m_valid_reg;
    logic [DIST_W-1:0] m_dist_reg;
    logic [NIDX_W-1:0] m_idx_reg;
    logic              m_found_reg;
    logic              m_last_reg;

    // Control
    logic s_accept;
    logic ld_we;
    logic [IDX_W-1:0] ld_addr;
    logic issue_rd;
    logic scan_done;
    logic sq_start;
    logic out_load;

    assign s_accept = s_tvalid && s_tready;

    // Load path: write address and enable
    always_comb begin
        ld_we   = s_accept && (s_tuser[0] == MODE_LOAD)
                  && (s_tuser[1] || (count_reg < CNT_W'(MAX_POINTS)));
        ld_addr = s_tuser[1] ? '0 : count_reg[IDX_W-1:0];
    end

    assign issue_rd  = (state_reg == ST_SCAN) && (rd_ptr_reg != count_reg);
    assign scan_done = (rd_ptr_reg == count_reg) && !v1_reg && !v2_reg && !v3_reg;

    // Next state and handshake control
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        sq_start   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser[0] == MODE_QUERY) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    sq_start   = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sq_bit_reg == '0) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Point memory write and read
    always_ff @(posedge aclk) begin
        if (ld_we) begin
            point_mem[ld_addr] <= s_tdata[PT_W-1:0];
        end
        rd_data_reg <= point_mem[rd_ptr_reg[IDX_W-1:0]];
    end

    // Point count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ld_we) begin
            count_reg <= s_tuser[1] ? CNT_W'(1) : count_reg + 1'b1;
        end
    end

    // Query capture and read pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
        end else if (s_accept) begin
            rd_ptr_reg <= '0;
        end else if (issue_rd) begin
            rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tuser[0] == MODE_QUERY) begin
            qx_reg    <= s_tdata[COORD_BITS-1:0];
            qy_reg    <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            qz_reg    <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
            final_reg <= s_tlast;
        end
    end

    // Absolute axis difference, clamped to 16 bits
    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic signed [SDIF_W-1:0] d;
        logic [SDIF_W-1:0]        mag;
        logic [SDIF_W+DIFF_W-1:0] magx;
        d    = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
        mag  = d[SDIF_W-1] ? SDIF_W'(-d) : SDIF_W'(d);
        magx = {{DIFF_W{1'b0}}, mag};
        if (magx > {{SDIF_W{1'b0}}, DIFF_CLAMP}) begin
            return DIFF_CLAMP;
        end
        return magx[DIFF_W-1:0];
    endfunction

    // Pipe valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= issue_rd;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Difference and square stages
    always_ff @(posedge aclk) begin
        idx1_reg <= rd_ptr_reg[IDX_W-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        dx_reg   <= abs_diff(qx_reg, rd_data_reg[COORD_BITS-1:0]);
        dy_reg   <= abs_diff(qy_reg, rd_data_reg[2*COORD_BITS-1:COORD_BITS]);
        dz_reg   <= abs_diff(qz_reg, rd_data_reg[3*COORD_BITS-1:2*COORD_BITS]);
        sx_reg   <= dx_reg * dx_reg;
        sy_reg   <= dy_reg * dy_reg;
        sz_reg   <= dz_reg * dz_reg;
    end

    // Sum and compare: strict less-than keeps the earlier point on a tie
    logic [SUM_W-1:0] dist_sum;
    assign dist_sum = SUM_W'(sx_reg) + SUM_W'(sy_reg) + SUM_W'(sz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg     <= CUTOFF_SQ;
            best_idx_reg <= '0;
            hit_reg      <= 1'b0;
        end else if (s_accept) begin
            best_reg     <= CUTOFF_SQ;
            best_idx_reg <= '0;
            hit_reg      <= 1'b0;
        end else if (v3_reg && dist_sum < SUM_W'(best_reg)) begin
            best_reg     <= dist_sum[BEST_W-1:0];
            best_idx_reg <= idx3_reg;
            hit_reg      <= 1'b1;
        end
    end

    // Square root, one result bit per cycle
    logic [ROOT_W-1:0] sq_trial;
    assign sq_trial = sq_root_reg + sq_bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_bit_reg <= '0;
        end else if (sq_start) begin
            sq_rem_reg  <= ROOT_W'(best_reg);
            sq_root_reg <= '0;
            sq_bit_reg  <= ROOT_BIT_INIT;
        end else if (state_reg == ST_SQRT && sq_bit_reg != '0) begin
            if (sq_rem_reg >= sq_trial) begin
                sq_rem_reg  <= sq_rem_reg - sq_trial;
                sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
            end else begin
                sq_root_reg <= sq_root_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    // Result fields
    logic [IDX_W+NIDX_W-1:0] best_idx_ext;
    logic                    is_interior;
    assign best_idx_ext = {{NIDX_W{1'b0}}, best_idx_reg};
    assign is_interior  = (best_idx_reg != '0)
                          && (CNT_W'(best_idx_reg) != count_reg - 1'b1);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_found_reg <= hit_reg && is_interior;
            m_dist_reg  <= hit_reg ? sq_root_reg[DIST_W-1:0] : '0;
            m_idx_reg   <= best_idx_ext[NIDX_W-1:0];
            m_last_reg  <= final_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_idx_reg, m_dist_reg};
    assign m_tuser  = m_found_reg;
    assign m_tlast  = m_last_reg;

    // Checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_rd_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_ptr_reg <= count_reg)
        else $error("read pointer past point count");

    a_best_cutoff: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_reg |-> best_reg < CUTOFF_SQ)
        else $error("winner not below cutoff");

    a_no_load_in_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |=> $stable(count_reg))
        else $error("point list changed during a query");

    a_result_after_sqrt: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> sq_bit_reg == '0)
        else $error("result loaded before square root finished");

endmodule : nearest_point_distance_search

`default_nettype wire

// ===== test/npds_result_checker.sv =====
`timescale 1ns / 1ps

module npds_result_checker
    import npds_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // coord_x, coord_y, coord_z, zero fill
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // mode, restart
    input  wire logic [1:0]                            s_tuser,
    input  wire logic                                  s_tlast,
    input  wire logic                                  s_tvalid,
    input  wire logic                                  s_tready,
    // distance, nearest_index, zero fill
    input  wire logic [((DIST_W+NIDX_W+7)/8)*8-1:0]    m_tdata,
    // found
    input  wire logic [0:0]                            m_tuser,
    input  wire logic                                  m_tlast,
    input  wire logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    output int                                         mismatch_count,
    output int                                         pending_results
);

    // squared distances are Q.16, the search radius is 999 squared units
    localparam longint unsigned CUTOFF_Q16 = 64'd999 << 16;
    localparam longint          AXIS_CLAMP = 65535;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic              found;
        logic [DIST_W-1:0] distance;
        logic [NIDX_W-1:0] nearest_index;
        logic              final_flag;
    } nearest_t;

    // shadow copy of the point list
    coord_t   stored_x [MAX_POINTS];
    coord_t   stored_y [MAX_POINTS];
    coord_t   stored_z [MAX_POINTS];
    int       stored_count;

    // predicted results, oldest first
    nearest_t awaited [$];

    // floored integer square root, one result bit per step
    function automatic longint unsigned floor_sqrt(longint unsigned value);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > value) probe >>= 2;
        while (probe != 0) begin
            if (value >= root + probe) begin
                value = value - (root + probe);
                root  = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // square of one axis difference, difference clamped to 16 bits
    function automatic longint unsigned axis_square(coord_t a, coord_t b);
        longint diff;
        diff = longint'(a) - longint'(b);
        if (diff < 0) diff = -diff;
        if (diff > AXIS_CLAMP) diff = AXIS_CLAMP;
        return longint'(diff * diff);
    endfunction

    // scan the list in index order; strict compare keeps the earlier point on a tie
    function automatic nearest_t predict_nearest(coord_t qx, coord_t qy, coord_t qz,
                                                 logic fin);
        nearest_t        res;
        longint unsigned best;
        longint unsigned dsq;
        int              best_at;
        bit              hit;
        best    = CUTOFF_Q16;
        best_at = 0;
        hit     = 1'b0;
        for (int j = 0; j < stored_count; j++) begin
            dsq = axis_square(qx, stored_x[j]) + axis_square(qy, stored_y[j])
                + axis_square(qz, stored_z[j]);
            if (dsq < best) begin
                best    = dsq;
                best_at = j;
                hit     = 1'b1;
            end
        end
        // endpoints of the polyline never count as found
        res.found         = hit && (best_at != 0) && (best_at != stored_count - 1);
        res.distance      = hit ? DIST_W'(floor_sqrt(best)) : '0;
        res.nearest_index = NIDX_W'(best_at);
        res.final_flag    = fin;
        return res;
    endfunction

    // watch both channels, predict on input transactions, compare on output ones
    always @(posedge aclk) begin : monitor
        nearest_t want;
        if (!aresetn) begin
            stored_count = 0;
            awaited.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result transaction with none expected: found=%0b "
                                 , $time, m_tuser[0],
                                 "distance=%0d index=%0d last=%0b",
                                 m_tdata[DIST_W-1:0], m_tdata[DIST_W+NIDX_W-1:DIST_W],
                                 m_tlast);
                end else begin
                    want = awaited.pop_front();
                    if (m_tuser[0] !== want.found
                            || m_tdata[DIST_W-1:0] !== want.distance
                            || m_tdata[DIST_W+NIDX_W-1:DIST_W] !== want.nearest_index
                            || m_tlast !== want.final_flag) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: result mismatch: expected found=%0b distance=%0d ",
                                     $time, want.found, want.distance,
                                     "index=%0d last=%0b, got found=%0b distance=%0d ",
                                     want.nearest_index, want.final_flag, m_tuser[0],
                                     m_tdata[DIST_W-1:0],
                                     "index=%0d last=%0b",
                                     m_tdata[DIST_W+NIDX_W-1:DIST_W], m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == MODE_QUERY) begin
                    awaited.push_back(predict_nearest(
                        coord_t'(s_tdata[COORD_BITS-1:0]),
                        coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]),
                        coord_t'(s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
                        s_tlast));
                end else begin
                    // restart empties the list; a full list drops the point
                    if (s_tuser[1]) stored_count = 0;
                    if (stored_count < MAX_POINTS) begin
                        stored_x[stored_count] = coord_t'(s_tdata[COORD_BITS-1:0]);
                        stored_y[stored_count] = coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
                        stored_z[stored_count] =
                            coord_t'(s_tdata[3*COORD_BITS-1:2*COORD_BITS]);
                        stored_count++;
                    end
                end
            end
        end
        pending_results <= awaited.size();
    end

endmodule

// ===== test/tb_nearest_point_distance_search.sv =====
`timescale 1ns / 1ps

module tb_nearest_point_distance_search;
    import npds_pkg::*;

    localparam int MAX_POINTS     = 1024;
    localparam int COORD_BITS     = 24;
    localparam int TDATA_W        = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int RDATA_W        = ((DIST_W + NIDX_W + 7) / 8) * 8;
    localparam int CLK_PERIOD     = 12;
    localparam int RANDOM_ITEMS   = 540;
    localparam int HOLD_CYCLES    = 800;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));
    // a bit beyond the search radius of about 8090 raw units
    localparam int NEAR_SPAN      = 9000;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]         s_tuser  = '0;
    logic               s_tlast  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [RDATA_W-1:0] m_tdata;
    logic [0:0]         m_tuser;
    logic               m_tlast;
    logic               m_tvalid;
    logic               m_tready = 1'b0;

    int mismatch_count;
    int pending_results;

    // points as the block should hold them, used to aim queries
    int list_x [$];
    int list_y [$];
    int list_z [$];

    int load_total;
    int query_total;
    int longest_list;
    int hold_requests;
    int drain_pauses;
    int burst_left;
    bit offering;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    nearest_point_distance_search #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    npds_result_checker #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    function automatic int clip_coord(longint value);
        if (value > COORD_MAX) return COORD_MAX;
        if (value < COORD_MIN) return COORD_MIN;
        return int'(value);
    endfunction

    // uniform over the whole signed coordinate range
    function automatic int any_coord();
        logic signed [COORD_BITS-1:0] value;
        value = COORD_BITS'($urandom());
        return int'(value);
    endfunction

    function automatic int jitter(int center, int span);
        return clip_coord(longint'(center) + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    // offer one transaction, wait for the handshake, then pace the burst
    task automatic send_item(input logic mode, input logic restart, input int x,
                             input int y, input int z, input logic fin);
        s_tdata  <= TDATA_W'({z[COORD_BITS-1:0], y[COORD_BITS-1:0], x[COORD_BITS-1:0]});
        s_tuser  <= {restart, mode};
        s_tlast  <= fin;
        s_tvalid <= 1'b1;
        offering = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (mode == MODE_LOAD) begin
            load_total++;
            if (restart) begin
                list_x.delete();
                list_y.delete();
                list_z.delete();
            end
            if (list_x.size() < MAX_POINTS) begin
                list_x.push_back(x);
                list_y.push_back(y);
                list_z.push_back(z);
            end
            if (list_x.size() > longest_list) longest_list = list_x.size();
        end else begin
            query_total++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // stop offering until every predicted result has been taken
    task automatic wait_results_drained();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    // result side: runs of ready patterns, plus long hold-offs on request
    initial begin : receiver
        int holds_served;
        int run_len;
        int style;
        holds_served = 0;
        @(posedge aclk);
        forever begin
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                style   = $urandom_range(0, 3);
                run_len = $urandom_range(1, 30);
                repeat (run_len) begin
                    case (style)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        2: m_tready <= ($urandom_range(0, 7) == 0);
                        default: m_tready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin : watchdog
        #(longint'(CLK_PERIOD) * TIMEOUT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int   i;
        int   q;
        int   k;
        int   m;
        int   n_q;
        int   list_len;
        int   kind;
        int   span;
        int   phase;
        int   directed_items;
        int   base_x;
        int   base_y;
        int   base_z;
        int   x;
        int   y;
        int   z;
        logic rst;
        logic fin;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list, restart flag on a query is ignored
        send_item(MODE_QUERY, 1'b1, 0, 0, 0, 1'b1);
        // single point: just inside and just outside the radius on one axis
        send_item(MODE_LOAD, 1'b1, 0, 0, 0, 1'b0);
        send_item(MODE_QUERY, 1'b0, 8091, 0, 0, 1'b0);
        send_item(MODE_QUERY, 1'b0, 0, -8092, 0, 1'b1);
        // squared distance of exactly 998 units, just below the cutoff of 999
        send_item(MODE_QUERY, 1'b0, -7936, 1536, -256, 1'b0);
        // coordinate extremes; the far corners need the difference clamp
        send_item(MODE_LOAD, 1'b0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_item(MODE_LOAD, 1'b0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_item(MODE_QUERY, 1'b0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_item(MODE_QUERY, 1'b0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        // duplicate point: tie keeps the earlier, now interior, index
        send_item(MODE_LOAD, 1'b0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_item(MODE_QUERY, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN + 5, 1'b1);
        send_item(MODE_QUERY, 1'b0, COORD_MAX, COORD_MIN, 0, 1'b0);
        send_item(MODE_QUERY, 1'b0, COORD_MIN, COORD_MAX, -1, 1'b0);
        // equidistant interior pair around the query, first point far away
        send_item(MODE_LOAD, 1'b1, 1000, -2000, 23000, 1'b0);
        send_item(MODE_LOAD, 1'b0, 5000, -2000, 3000, 1'b0);
        send_item(MODE_LOAD, 1'b0, -3000, -2000, 3000, 1'b1);
        send_item(MODE_LOAD, 1'b0, 1000, -2000, 12000, 1'b0);
        send_item(MODE_QUERY, 1'b0, 1000, -2000, 3000, 1'b0);
        send_item(MODE_QUERY, 1'b0, 5000, -2000, 3000, 1'b1);
        send_item(MODE_QUERY, 1'b0, 1000, -2000, 12000, 1'b1);

        // random list phases, each a fresh list followed by a batch of queries
        directed_items = load_total + query_total;
        phase = 0;
        while (load_total + query_total - directed_items < RANDOM_ITEMS) begin
            phase++;
            kind = $urandom_range(0, 9);
            if (kind == 0) list_len = 1;
            else if (kind == 1) list_len = 2;
            else if (kind >= 8) list_len = $urandom_range(13, 40);
            else list_len = $urandom_range(3, 12);
            base_x = any_coord();
            base_y = any_coord();
            base_z = any_coord();
            span = $urandom_range(0, 1) ? 6000 : 30000;
            for (i = 0; i < list_len; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    x = any_coord();
                    y = any_coord();
                    z = any_coord();
                end else begin
                    x = jitter(base_x, span);
                    y = jitter(base_y, span);
                    z = jitter(base_z, span);
                end
                send_item(MODE_LOAD, (i == 0) || ($urandom_range(0, 39) == 0), x, y, z,
                          1'($urandom_range(0, 1)));
            end

            // now and then the receiver stops for a long while with queries queued
            if (phase % 16 == 5) begin
                wait_results_drained();
                drain_pauses++;
                hold_requests++;
                n_q = 6;
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    wait_results_drained();
                    drain_pauses++;
                end
                n_q = $urandom_range(1, 8);
            end

            for (q = 0; q < n_q; q++) begin
                k    = $urandom_range(0, list_x.size() - 1);
                m    = $urandom_range(0, list_x.size() - 1);
                span = $urandom_range(0, 1) ? 2000 : NEAR_SPAN;
                rst  = 1'b0;
                kind = $urandom_range(0, 9);
                case (kind)
                    6: begin
                        x = list_x[k];
                        y = list_y[k];
                        z = list_z[k];
                    end
                    7: begin
                        // halfway between two points: ties whenever they are symmetric
                        x = clip_coord((longint'(list_x[k]) + list_x[m]) / 2);
                        y = clip_coord((longint'(list_y[k]) + list_y[m]) / 2);
                        z = clip_coord((longint'(list_z[k]) + list_z[m]) / 2);
                    end
                    8: begin
                        x = any_coord();
                        y = any_coord();
                        z = any_coord();
                    end
                    default: begin
                        x   = jitter(list_x[k], span);
                        y   = jitter(list_y[k], span);
                        z   = jitter(list_z[k], span);
                        rst = (kind == 9);
                    end
                endcase
                fin = (q == n_q - 1) || ($urandom_range(0, 3) == 0);
                send_item(MODE_QUERY, rst, x, y, z, fin);
                // stray load appended between queries
                if ($urandom_range(0, 5) == 0)
                    send_item(MODE_LOAD, 1'b0, jitter(base_x, span), jitter(base_y, span),
                              jitter(base_z, span), 1'($urandom_range(0, 1)));
            end
        end

        wait_results_drained();
        repeat (list_x.size() + 40) @(posedge aclk);

        $display("Run covered %0d point loads and %0d queries, lists up to %0d points,",
                 load_total, query_total, longest_list);
        $display("with %0d long receiver hold-offs and %0d sender pauses to empty.",
                 hold_requests, drain_pauses);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
